### src/ptw_mmu_pkg.sv
`default_nettype none
package ptw_mmu_pkg;
    localparam int PHYS_ADDR_BITS_DEF = 16;

    localparam logic [1:0] OP_VREAD  = 2'd0;
    localparam logic [1:0] OP_VWRITE = 2'd1;
    localparam logic [1:0] OP_PREAD  = 2'd2;
    localparam logic [1:0] OP_PWRITE = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_DIR_NP = 2'd1;
    localparam logic [1:0] STAT_TBL_NP = 2'd2;

    localparam logic [1:0] CFG_PAGING   = 2'd0;
    localparam logic [1:0] CFG_DIR_BASE = 2'd1;

    localparam logic [31:0] FRAME_MASK = 32'hFFFFF000;
    localparam logic [12:0] PAGE_BYTES = 13'd4096;
endpackage
`default_nettype wire

### src/ptw_mmu_mem.sv
`default_nettype none
module ptw_mmu_mem
    import ptw_mmu_pkg::*;
#(
    parameter int ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [7:0]           wdata,
    output logic      [7:0]           rdata
);
    logic [7:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end
endmodule
`default_nettype wire

### src/two_level_page_walk_mmu_core.sv
`default_nettype none
// Two-level page-walk MMU with a private byte-wide physical memory. One access
// of 1..4 bytes per item; op in s_tuser, status in m_tuser. The memory has a
// single port, one byte per cycle, so everything is byte-serial through it:
// each table entry is read as 4 bytes, a translation reads a directory
// entry and then a table entry, a page-crossing access needs two
// translations, and then the len data bytes are written or read in turn.
// The result sits in an output register, so a new item is taken while it
// waits. Memory contents are undefined until written; there is no clearing.
module two_level_page_walk_mmu_core
    import ptw_mmu_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // addr[31:0], wdata[63:32], len[66:64], zero
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // rdata[31:0]
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic        paging_reg, dir_base_w;
    logic [31:0] dir_base_reg;
    logic        wr_reg, wr_next;
    logic [31:0] va_reg, va_next, addr_reg, addr_next, wdata_reg, wdata_next;
    logic [2:0]  len_reg, len_next, flen_reg, flen_next;
    logic [31:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [31:0] ebase_reg, ebase_next;
    logic        level_reg, level_next, piece_reg, piece_next;
    logic [2:0]  ic_reg, ic_next;
    logic        rv_reg, rv_next;
    logic [1:0]  ridx_reg, ridx_next;
    logic [31:0] word_reg, word_next, full_word;
    logic [1:0]  stat_reg, stat_next;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic                      mem_en, mem_we;
    logic [31:0]               mem_addr32;
    logic [7:0]                mem_wdata, mem_rdata;

    logic [2:0]  in_len;
    logic [12:0] room;
    logic [31:0] pa_calc, data_pa;
    logic [2:0]  di_second;

    ptw_mmu_mem #(.ADDR_BITS(PHYS_ADDR_BITS)) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr32[PHYS_ADDR_BITS-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign dir_base_w = cfg_valid && (cfg_index == CFG_DIR_BASE);

    always_comb begin
        full_word = word_reg;
        full_word[ridx_reg*8 +: 8] = mem_rdata;
        in_len = (s_tdata[66:64] > 3'd4) ? 3'd4 : s_tdata[66:64];
        room = PAGE_BYTES - {1'b0, s_tdata[11:0]};
        pa_calc = (full_word & FRAME_MASK) + {20'd0, va_reg[11:0]};
        di_second = ic_reg - flen_reg;
        data_pa = (ic_reg < flen_reg) ? p1_reg + {29'd0, ic_reg}
                                      : p2_reg + {29'd0, di_second};
    end

    always_comb begin
        state_next = state_reg;
        wr_next    = wr_reg;
        va_next    = va_reg;
        addr_next  = addr_reg;
        wdata_next = wdata_reg;
        len_next   = len_reg;
        flen_next  = flen_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        ebase_next = ebase_reg;
        level_next = level_reg;
        piece_next = piece_reg;
        ic_next    = ic_reg;
        rv_next    = 1'b0;
        ridx_next  = ic_reg[1:0];
        word_next  = word_reg;
        stat_next  = stat_reg;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr32 = ebase_reg + {29'd0, ic_reg};
        mem_wdata  = wdata_reg[ic_reg[1:0]*8 +: 8];
        if (rv_reg) begin
            word_next = full_word;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    wr_next    = s_tuser[0];
                    addr_next  = s_tdata[31:0];
                    va_next    = s_tdata[31:0];
                    wdata_next = s_tdata[63:32];
                    len_next   = in_len;
                    flen_next  = in_len;
                    p1_next    = s_tdata[31:0];
                    stat_next  = STAT_OK;
                    word_next  = '0;
                    ic_next    = '0;
                    level_next = 1'b0;
                    piece_next = 1'b0;
                    ebase_next = dir_base_reg + {20'd0, s_tdata[31:22], 2'b00};
                    if (in_len == 3'd0) begin
                        state_next = S_DONE;
                    end else if (!s_tuser[1] && paging_reg) begin
                        if (room < {10'd0, in_len}) begin
                            flen_next = room[2:0];
                        end
                        state_next = S_WALK;
                    end else begin
                        state_next = S_DATA;
                    end
                end
            end
            S_WALK: begin
                if (ic_reg < 3'd4) begin
                    mem_en  = 1'b1;
                    rv_next = 1'b1;
                    ic_next = ic_reg + 3'd1;
                end
                if (rv_reg && ridx_reg == 2'd3) begin
                    ic_next = '0;
                    if (!full_word[0]) begin
                        stat_next  = level_reg ? STAT_TBL_NP : STAT_DIR_NP;
                        state_next = S_DONE;
                    end else if (!level_reg) begin
                        level_next = 1'b1;
                        ebase_next = (full_word & FRAME_MASK)
                                   + {20'd0, va_reg[21:12], 2'b00};
                    end else if (!piece_reg) begin
                        p1_next = pa_calc;
                        if (flen_reg < len_reg) begin
                            piece_next = 1'b1;
                            level_next = 1'b0;
                            va_next    = addr_reg + {29'd0, flen_reg};
                            ebase_next = dir_base_reg
                                       + {20'd0, va_next[31:22], 2'b00};
                        end else begin
                            word_next  = '0;
                            state_next = S_DATA;
                        end
                    end else begin
                        p2_next    = pa_calc;
                        word_next  = '0;
                        state_next = S_DATA;
                    end
                end
            end
            S_DATA: begin
                mem_addr32 = data_pa;
                if (ic_reg < len_reg) begin
                    mem_en  = 1'b1;
                    mem_we  = wr_reg;
                    rv_next = !wr_reg;
                    ic_next = ic_reg + 3'd1;
                    if (wr_reg && ic_reg == len_reg - 3'd1) begin
                        state_next = S_DONE;
                    end
                end
                if (rv_reg && {1'b0, ridx_reg} == len_reg - 3'd1) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            paging_reg   <= 1'b0;
            dir_base_reg <= '0;
            rv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            if (cfg_valid && cfg_index == CFG_PAGING) begin
                paging_reg <= cfg_data[0];
            end
            if (dir_base_w) begin
                dir_base_reg <= cfg_data;
            end
            if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_reg    <= wr_next;
        va_reg    <= va_next;
        addr_reg  <= addr_next;
        wdata_reg <= wdata_next;
        len_reg   <= len_next;
        flen_reg  <= flen_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        ebase_reg <= ebase_next;
        level_reg <= level_next;
        piece_reg <= piece_next;
        ic_reg    <= ic_next;
        ridx_reg  <= ridx_next;
        word_reg  <= word_next;
        stat_reg  <= stat_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_data_reg <= (wr_reg || stat_reg != STAT_OK) ? 32'd0 : word_reg;
            m_user_reg <= stat_reg;
        end
    end

    a_we_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_DATA && wr_reg && stat_reg == STAT_OK))
        else $error("memory write outside data phase");
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg != STAT_OK) |-> (m_data_reg == 32'd0))
        else $error("fault result carries data");
    a_no_issue_past_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DATA && mem_en) |-> (ic_reg < len_reg))
        else $error("data access beyond length");
    a_walk_word_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK && rv_reg && ridx_reg == 2'd3) |-> (ic_reg == 3'd4))
        else $error("entry evaluated before all bytes read");
endmodule
`default_nettype wire
